[rtl/pstt_pkg.sv]
// ----------------------------------------------------------------------------
// pstt_pkg
// types and codes shared by the periodic software timer table
// ----------------------------------------------------------------------------
`default_nettype none

package pstt_pkg;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_NOT_INIT  = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FIRED  = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  task_id;
        logic [31:0] period;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [7:0]  fired_id;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  id;
        logic [31:0] period;
        logic [31:0] count;
    } t_slot;

endpackage

`default_nettype wire

[rtl/pstt_slot_ram.sv]
// ----------------------------------------------------------------------------
// pstt_slot_ram
// slot table memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pstt_slot_ram import pstt_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_slot              o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_slot         i_wr_data
);

    t_slot r_mem [DEPTH];
    t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[rtl/periodic_software_timer_table_unit.sv]
// ----------------------------------------------------------------------------
// periodic_software_timer_table_unit
// table of periodic timers kept in a slot memory, walked by read-modify-write
// ----------------------------------------------------------------------------
// start and clear load their status in S_RESP, which goes to the result register
// once the output is free; stop and tick walk the occupied slots one per cycle
// through the slot memory read port, tick stalling while a fired result is blocked
// one request at a time; the next is taken once the final status is loaded
// synchronous active-low reset empties the table and clears enable, no sweep
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_software_timer_table_unit import pstt_pkg::*; #(
    parameter int SLOTS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_data,
    input  wire logic     i_cfg_valid,
    output logic          o_cfg_ready,
    input  wire logic     i_cfg_data
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_STOP = 4'b0010,
        S_TICK = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic             r_enabled;
    logic [CNT_W-1:0] r_used, n_used;
    logic [SLOTS-1:0] r_active, n_active;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [7:0]       r_id, n_id;
    logic             r_found, n_found;
    logic [1:0]       r_status, n_status;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    t_slot            rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_slot            wr_data;

    logic             out_free;
    logic             last_slot;
    logic [31:0]      cnt_inc;
    logic             tick_hit;
    logic             id_match;

    pstt_slot_ram #(
        .DEPTH (SLOTS),
        .AW    (IDX_W)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    assign out_free  = !r_out_valid || i_out_ready;
    assign last_slot = (CNT_W'(r_idx) + CNT_W'(1)) == r_used;
    assign cnt_inc   = rd_data.count + 32'd1;
    assign tick_hit  = r_active[r_idx] && (cnt_inc == rd_data.period);
    assign id_match  = rd_data.id == r_id;

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_active    = r_active;
        n_idx       = r_idx;
        n_id        = r_id;
        n_found     = r_found;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        rd_en       = 1'b0;
        rd_addr     = r_idx + IDX_W'(1);
        wr_en       = 1'b0;
        wr_addr     = r_idx;
        wr_data     = rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_id    = i_in_data.task_id;
                    n_state = S_RESP;
                    unique case (i_in_data.command)
                        CMD_STOP: begin
                            n_status = ST_NOT_FOUND;
                            if (r_used != '0) begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_state = S_STOP;
                            end
                        end
                        CMD_START: begin
                            if (!r_enabled) begin
                                n_status = ST_NOT_INIT;
                            end else if (r_used == CNT_W'(SLOTS)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_status              = ST_OK;
                                wr_en                 = 1'b1;
                                wr_addr               = r_used[IDX_W-1:0];
                                wr_data.id            = i_in_data.task_id;
                                wr_data.period        = i_in_data.period;
                                wr_data.count         = '0;
                                n_active[r_used[IDX_W-1:0]] = 1'b1;
                                n_used                = r_used + CNT_W'(1);
                            end
                        end
                        CMD_TICK: begin
                            if (!r_enabled) begin
                                n_status = ST_NOT_INIT;
                            end else begin
                                n_status = ST_OK;
                                if (r_used != '0) begin
                                    rd_en   = 1'b1;
                                    rd_addr = '0;
                                    n_state = S_TICK;
                                end
                            end
                        end
                        CMD_CLEAR: begin
                            if (!r_enabled) begin
                                n_status = ST_NOT_INIT;
                            end else begin
                                n_status = ST_OK;
                                n_used   = '0;
                                n_active = '0;
                            end
                        end
                    endcase
                end
            end
            S_STOP: begin
                if (id_match) begin
                    n_active[r_idx] = 1'b0;
                    n_found         = 1'b1;
                end
                if (last_slot) begin
                    n_status = (r_found || id_match) ? ST_OK : ST_NOT_FOUND;
                    n_state  = S_RESP;
                end else begin
                    rd_en = 1'b1;
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_TICK: begin
                if (!tick_hit || out_free) begin
                    wr_en         = 1'b1;
                    wr_data.count = tick_hit ? 32'd0 : cnt_inc;
                    if (tick_hit) begin
                        n_out.kind     = KIND_FIRED;
                        n_out.status   = ST_OK;
                        n_out.fired_id = rd_data.id;
                        n_out.last     = 1'b0;
                        n_out_valid    = 1'b1;
                    end
                    if (last_slot) begin
                        n_state = S_RESP;
                    end else begin
                        rd_en = 1'b1;
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out.kind     = KIND_STATUS;
                    n_out.status   = r_status;
                    n_out.fired_id = 8'd0;
                    n_out.last     = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enabled   <= 1'b0;
            r_used      <= '0;
            r_active    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_enabled <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_id     <= n_id;
        r_found  <= n_found;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(SLOTS))
        else $error("slot count beyond table size");

    a_active_occupied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active >> r_used) == '0)
        else $error("active slot outside occupied range");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while previous one in progress");

    a_fired_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_FIRED) |-> (!r_out.last && r_out.status == ST_OK))
        else $error("fired result marked last or with status");

    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last) |-> (r_out.kind == KIND_STATUS && r_out.fired_id == 8'd0))
        else $error("final result is not a status");

endmodule

`default_nettype wire

[dv/periodic_software_timer_table_unit_tb.sv]
// ----------------------------------------------------------------------------
// periodic_software_timer_table_unit_tb
// Drives start, stop, tick and clear requests into the timer table and checks
// every status and fired result against a cycle-free model of the table kept
// in the bench. A short directed table covers the disabled, full, not-found,
// duplicate id and extreme period cases; random traffic follows in three
// phases with different request gaps and back-pressure on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_software_timer_table_unit_tb;
    import pstt_pkg::*;

    localparam int TBL_SLOTS   = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 40;

    typedef struct {
        bit         is_cfg;
        logic       cfg_val;
        t_in_item   req;
        bit         typed;
        logic [1:0] typed_st;
    } t_dir_row;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      i_cfg_valid = 1'b0;
    logic      i_cfg_data  = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      o_cfg_ready;

    // table model
    logic [7:0]  tbl_id     [TBL_SLOTS];
    logic [31:0] tbl_period [TBL_SLOTS];
    logic [31:0] tbl_count  [TBL_SLOTS];
    bit          tbl_active [TBL_SLOTS];
    int          tbl_used;
    logic        tbl_enabled;

    t_out_item pending_results[$];
    t_dir_row  dir_rows[$];
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    int        snd_idle_pct   = 9;
    int        rcv_idle_pct   = 66;

    periodic_software_timer_table_unit #(.SLOTS(TBL_SLOTS)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("mismatch at %0t: %s", $time, what);
        end
    endtask

    function automatic void push_status(input logic [1:0] st);
        pending_results.push_back('{kind: KIND_STATUS, status: st, fired_id: 8'h00,
                                    last: 1'b1});
    endfunction

    function automatic void advance_timer_table(input t_in_item r);
        bit found;
        found = 1'b0;
        if (r.command == CMD_STOP) begin
            for (int i = 0; i < tbl_used; i++) begin
                if (tbl_id[i] == r.task_id) begin
                    tbl_active[i] = 1'b0;
                    found = 1'b1;
                end
            end
            push_status(found ? ST_OK : ST_NOT_FOUND);
            return;
        end
        if (!tbl_enabled) begin
            push_status(ST_NOT_INIT);
            return;
        end
        case (r.command)
            CMD_START: begin
                if (tbl_used < TBL_SLOTS) begin
                    tbl_id[tbl_used]     = r.task_id;
                    tbl_period[tbl_used] = r.period;
                    tbl_count[tbl_used]  = '0;
                    tbl_active[tbl_used] = 1'b1;
                    tbl_used++;
                    push_status(ST_OK);
                end else begin
                    push_status(ST_FULL);
                end
            end
            CMD_CLEAR: begin
                tbl_used = 0;
                for (int i = 0; i < TBL_SLOTS; i++) tbl_active[i] = 1'b0;
                push_status(ST_OK);
            end
            default: begin
                for (int i = 0; i < TBL_SLOTS; i++) begin
                    tbl_count[i] = tbl_count[i] + 32'd1;
                    if (tbl_active[i] && tbl_count[i] == tbl_period[i]) begin
                        pending_results.push_back('{kind: KIND_FIRED, status: ST_OK,
                                                    fired_id: tbl_id[i], last: 1'b0});
                        tbl_count[i] = '0;
                    end
                end
                push_status(ST_OK);
            end
        endcase
    endfunction

    task automatic send_req(input t_in_item r, input bit typed, input logic [1:0] typed_st);
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (!o_in_ready);
        advance_timer_table(r);
        if (typed) begin
            void'(pending_results.pop_back());
            push_status(typed_st);
        end
    endtask

    task automatic drain_requests();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_enable(input logic val);
        drain_requests();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        tbl_enabled = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void add_row(input bit is_cfg, input logic cfg_val,
                                    input logic [1:0] cmd, input logic [7:0] id,
                                    input logic [31:0] per, input bit typed,
                                    input logic [1:0] st);
        t_dir_row row;
        row.is_cfg   = is_cfg;
        row.cfg_val  = cfg_val;
        row.req      = '{command: cmd, task_id: id, period: per};
        row.typed    = typed;
        row.typed_st = st;
        dir_rows.push_back(row);
    endfunction

    task automatic run_random(input int n_items);
        logic [7:0] id_pool [8] = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80, 8'h3C, 8'hC3};
        t_in_item   r;
        int         sel;
        for (int k = 0; k < n_items; k++) begin
            sel       = $urandom_range(99);
            r.task_id = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                 : id_pool[$urandom_range(7)];
            r.period  = $urandom;
            if (sel < 40) begin
                r.command = CMD_START;
                case ($urandom_range(9))
                    0:       r.period = $urandom;
                    1:       r.period = '0;
                    default: r.period = 32'($urandom_range(6, 1));
                endcase
            end else if (sel < 52) begin
                r.command = CMD_STOP;
            end else if (sel < 96) begin
                r.command = CMD_TICK;
            end else begin
                r.command = CMD_CLEAR;
            end
            send_req(r, 1'b0, ST_OK);
        end
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", o_out_data));
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.kind !== want.kind)
                    report_mismatch($sformatf("kind %0b, want %0b",
                                              o_out_data.kind, want.kind));
                if (o_out_data.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              o_out_data.status, want.status));
                if (o_out_data.fired_id !== want.fired_id)
                    report_mismatch($sformatf("fired_id %h, want %h",
                                              o_out_data.fired_id, want.fired_id));
                if (o_out_data.last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b",
                                              o_out_data.last, want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        tbl_used    = 0;
        tbl_enabled = 1'b0;
        for (int i = 0; i < TBL_SLOTS; i++) begin
            tbl_id[i]     = '0;
            tbl_period[i] = '0;
            tbl_count[i]  = '0;
            tbl_active[i] = 1'b0;
        end

        //       cfg   val   command    id     period        typed  status
        add_row(1'b0, 1'b0, CMD_START, 8'h00, 32'd0,        1'b1,  ST_NOT_INIT);
        add_row(1'b0, 1'b0, CMD_TICK,  8'hFF, 32'hFFFFFFFF, 1'b1,  ST_NOT_INIT);
        add_row(1'b0, 1'b0, CMD_CLEAR, 8'h00, 32'd0,        1'b1,  ST_NOT_INIT);
        add_row(1'b0, 1'b0, CMD_STOP,  8'hFF, 32'd0,        1'b1,  ST_NOT_FOUND);
        add_row(1'b1, 1'b1, CMD_START, 8'h00, 32'd0,        1'b0,  ST_OK);
        add_row(1'b0, 1'b0, CMD_START, 8'h00, 32'd1,        1'b1,  ST_OK);
        add_row(1'b0, 1'b0, CMD_START, 8'hFF, 32'hFFFFFFFF, 1'b1,  ST_OK);
        add_row(1'b0, 1'b0, CMD_START, 8'hA5, 32'd0,        1'b1,  ST_OK);
        add_row(1'b0, 1'b0, CMD_START, 8'h5A, 32'd2,        1'b1,  ST_OK);
        add_row(1'b0, 1'b0, CMD_START, 8'h5A, 32'd3,        1'b1,  ST_OK);
        add_row(1'b0, 1'b0, CMD_TICK,  8'h00, 32'd0,        1'b0,  ST_OK);
        add_row(1'b0, 1'b0, CMD_TICK,  8'hFF, 32'hFFFFFFFF, 1'b0,  ST_OK);
        add_row(1'b0, 1'b0, CMD_TICK,  8'h00, 32'd0,        1'b0,  ST_OK);
        add_row(1'b0, 1'b0, CMD_STOP,  8'h5A, 32'd0,        1'b1,  ST_OK);
        add_row(1'b0, 1'b0, CMD_STOP,  8'h33, 32'd0,        1'b1,  ST_NOT_FOUND);
        for (int i = 0; i < 11; i++)
            add_row(1'b0, 1'b0, CMD_START, 8'h80 | 8'(i), 32'd1, 1'b1, ST_OK);
        add_row(1'b0, 1'b0, CMD_START, 8'h77, 32'd1,        1'b1,  ST_FULL);
        add_row(1'b0, 1'b0, CMD_TICK,  8'h00, 32'd0,        1'b0,  ST_OK);
        add_row(1'b1, 1'b0, CMD_START, 8'h00, 32'd0,        1'b0,  ST_OK);
        add_row(1'b0, 1'b0, CMD_STOP,  8'h00, 32'd0,        1'b1,  ST_OK);
        add_row(1'b1, 1'b1, CMD_START, 8'h00, 32'd0,        1'b0,  ST_OK);
        add_row(1'b0, 1'b0, CMD_CLEAR, 8'hFF, 32'hFFFFFFFF, 1'b1,  ST_OK);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                write_enable(dir_rows[i].cfg_val);
            end else begin
                send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].typed_st);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            snd_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 66 : 0;
            rcv_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 9 : 0;
            write_enable(1'b1);
            run_random(90);
            write_enable(1'b0);
            run_random(10);
        end

        drain_requests();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/pstt_pkg.sv
rtl/pstt_slot_ram.sv
rtl/periodic_software_timer_table_unit.sv
dv/periodic_software_timer_table_unit_tb.sv
